// ===== design/i2cms_pkg.sv =====
package i2cms_pkg;

    // Bus step currently being held on SCL/SDA.
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_RESTART = 4'd1,
        PH_ST_SDA  = 4'd2,
        PH_ST_SCL  = 4'd3,
        PH_WB_SET  = 4'd4,
        PH_WB_HIGH = 4'd5,
        PH_WB_LOW  = 4'd6,
        PH_RB_HIGH = 4'd7,
        PH_RB_LOW  = 4'd8,
        PH_SP_A    = 4'd9,
        PH_SP_B    = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        OP_NONE        = 3'd0,
        OP_START_WRITE = 3'd1,
        OP_START_READ  = 3'd2,
        OP_WRITE       = 3'd3,
        OP_READ        = 3'd4,
        OP_STOP        = 3'd5
    } op_t;

    localparam int unsigned ADDR_W     = 3;
    localparam int unsigned DELAY_W    = 16;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned BIT_IDX_W  = 4;
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 32;

    localparam logic [ADDR_W-1:0]    REG_DELAY_TICKS = 3'd0;
    localparam logic [DELAY_W-1:0]   DELAY_RESET     = 16'd5;
    localparam logic [BIT_IDX_W-1:0] BITS_PER_BYTE   = 4'd8;
    localparam logic                 RW_READ         = 1'b1;
    localparam logic                 RW_WRITE        = 1'b0;

endpackage

// ===== design/i2c_master_bit_sequencer.sv =====
// Channel   | Direction | Handshake         | Content
// s_axis    | in        | tvalid/tready     | one bus tick: command (tuser) and operands (tdata)
// m_axis    | out       | tvalid/tready     | bus pin levels and status after that tick
// apb       | in        | psel/penable      | delay_ticks register at byte address 0
//
// Every accepted tick updates the sequencer state; its result is held in a
// single output register, so one tick can be accepted per cycle.
// The next tick is accepted while the held result is being taken, and input
// stalls only when the output register is full and not taken.
// Reset returns the bus to idle (SCL and SDA released) and delay_ticks to 5.
module i2c_master_bit_sequencer
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // [2:0] op
    // [6:0] target_address, [14:7] tx_byte, [30:15] read_count, [31] sda_in
    input  logic [31:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] scl_out, [1] sda_release, [2] busy_res, [3] done_res, [4] ack_ok,
    // [12:5] rx_byte, [28:13] bytes_left, [29] bus_started, [31:30] zero
    output logic [31:0] m_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [i2cms_pkg::DELAY_W-1:0] delay_ticks_reg;

    i2cms_pkg::phase_t                 phase_reg, phase_next;
    logic                              started_reg, started_next;
    logic [i2cms_pkg::COUNT_W-1:0]     remaining_reg, remaining_next;
    logic [7:0]                        shift_reg, shift_next;
    logic [i2cms_pkg::BIT_IDX_W-1:0]   bit_index_reg, bit_index_next;
    logic [i2cms_pkg::DELAY_W-1:0]     delay_count_reg, delay_count_next;
    i2cms_pkg::op_t                    active_op_reg, active_op_next;
    logic [i2cms_pkg::COUNT_W-1:0]     pending_reg, pending_next;
    logic                              ack_reg, ack_next;
    logic                              scl_reg, scl_next;
    logic                              sda_reg, sda_next;
    logic [7:0]                        rx_last_reg, rx_last_next;
    logic                              done_next;

    logic                              m_tvalid_reg;
    logic [i2cms_pkg::OUT_DATA_W-1:0]  m_tdata_reg;

    i2cms_pkg::op_t                    in_op;
    logic [6:0]                        in_addr;
    logic [7:0]                        in_txb;
    logic [i2cms_pkg::COUNT_W-1:0]     in_cnt;
    logic                              in_sda;
    logic                              accept;

    logic                              enter_en;
    i2cms_pkg::phase_t                 enter_ph;
    logic                              enter_bit;
    logic [i2cms_pkg::DELAY_W-1:0]     step_ticks;
    logic [2:0]                        bit_sel;

    assign in_op   = i2cms_pkg::op_t'(s_tuser);
    assign in_addr = s_tdata[6:0];
    assign in_txb  = s_tdata[14:7];
    assign in_cnt  = s_tdata[30:15];
    assign in_sda  = s_tdata[31];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == i2cms_pkg::REG_DELAY_TICKS) ?
                    {16'd0, delay_ticks_reg} : 32'd0;

    // A zero delay still holds each step for one tick.
    assign step_ticks = (delay_ticks_reg == '0) ? 16'd1 : delay_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_ticks_reg <= i2cms_pkg::DELAY_RESET;
        end
        else if (psel && penable && pwrite && pready &&
                 paddr == i2cms_pkg::REG_DELAY_TICKS)
        begin
            delay_ticks_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        started_next     = started_reg;
        remaining_next   = remaining_reg;
        shift_next       = shift_reg;
        bit_index_next   = bit_index_reg;
        delay_count_next = delay_count_reg;
        active_op_next   = active_op_reg;
        pending_next     = pending_reg;
        ack_next         = ack_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        rx_last_next     = rx_last_reg;
        done_next        = 1'b0;
        enter_en         = 1'b0;
        enter_ph         = i2cms_pkg::PH_IDLE;
        enter_bit        = 1'b0;
        bit_sel          = 3'd0;

        if (phase_reg == i2cms_pkg::PH_IDLE)
        begin
            case (in_op)
                i2cms_pkg::OP_START_WRITE,
                i2cms_pkg::OP_START_READ:
                begin
                    active_op_next = in_op;
                    bit_index_next = '0;
                    shift_next     = {in_addr, (in_op == i2cms_pkg::OP_START_READ) ?
                                      i2cms_pkg::RW_READ : i2cms_pkg::RW_WRITE};
                    pending_next   = in_cnt;
                    enter_en       = 1'b1;
                    enter_ph       = started_reg ? i2cms_pkg::PH_RESTART :
                                                   i2cms_pkg::PH_ST_SDA;
                end
                i2cms_pkg::OP_WRITE:
                begin
                    active_op_next = in_op;
                    bit_index_next = '0;
                    shift_next     = in_txb;
                    enter_en       = 1'b1;
                    enter_ph       = i2cms_pkg::PH_WB_SET;
                    enter_bit      = in_txb[7];
                end
                i2cms_pkg::OP_READ:
                begin
                    active_op_next = in_op;
                    bit_index_next = '0;
                    shift_next     = '0;
                    enter_en       = 1'b1;
                    enter_ph       = i2cms_pkg::PH_RB_HIGH;
                end
                i2cms_pkg::OP_STOP:
                begin
                    active_op_next = in_op;
                    bit_index_next = '0;
                    enter_en       = 1'b1;
                    enter_ph       = i2cms_pkg::PH_SP_A;
                end
                default:
                begin
                end
            endcase
        end
        else if (delay_count_reg > 16'd1)
        begin
            delay_count_next = delay_count_reg - 16'd1;
        end
        else
        begin
            delay_count_next = '0;
            case (phase_reg)
                i2cms_pkg::PH_RESTART:
                begin
                    enter_en = 1'b1;
                    enter_ph = i2cms_pkg::PH_ST_SDA;
                end
                i2cms_pkg::PH_ST_SDA:
                begin
                    enter_en = 1'b1;
                    enter_ph = i2cms_pkg::PH_ST_SCL;
                end
                i2cms_pkg::PH_ST_SCL:
                begin
                    started_next   = 1'b1;
                    bit_index_next = '0;
                    enter_en       = 1'b1;
                    enter_ph       = i2cms_pkg::PH_WB_SET;
                    enter_bit      = shift_reg[7];
                end
                i2cms_pkg::PH_WB_SET:
                begin
                    enter_en = 1'b1;
                    enter_ph = i2cms_pkg::PH_WB_HIGH;
                end
                i2cms_pkg::PH_WB_HIGH:
                begin
                    enter_en = 1'b1;
                    enter_ph = i2cms_pkg::PH_WB_LOW;
                end
                i2cms_pkg::PH_WB_LOW:
                begin
                    if (active_op_reg == i2cms_pkg::OP_READ)
                    begin
                        // This was the ACK/NACK slot after a received byte.
                        if (sda_reg)
                        begin
                            remaining_next = '0;
                            enter_en       = 1'b1;
                            enter_ph       = i2cms_pkg::PH_SP_A;
                        end
                        else
                        begin
                            remaining_next = remaining_reg - 16'd1;
                            done_next      = 1'b1;
                        end
                    end
                    else
                    begin
                        bit_index_next = bit_index_reg + 4'd1;
                        bit_sel        = 3'd7 - bit_index_next[2:0];
                        enter_en       = 1'b1;
                        if (bit_index_next < i2cms_pkg::BITS_PER_BYTE)
                        begin
                            enter_ph  = i2cms_pkg::PH_WB_SET;
                            enter_bit = shift_reg[bit_sel];
                        end
                        else
                        begin
                            enter_ph = i2cms_pkg::PH_RB_HIGH;
                        end
                    end
                end
                i2cms_pkg::PH_RB_HIGH:
                begin
                    enter_en = 1'b1;
                    enter_ph = i2cms_pkg::PH_RB_LOW;
                end
                i2cms_pkg::PH_RB_LOW:
                begin
                    if (active_op_reg == i2cms_pkg::OP_READ)
                    begin
                        bit_index_next = bit_index_reg + 4'd1;
                        enter_en       = 1'b1;
                        if (bit_index_next < i2cms_pkg::BITS_PER_BYTE)
                        begin
                            enter_ph = i2cms_pkg::PH_RB_HIGH;
                        end
                        else
                        begin
                            // NACK the last byte, ACK all others.
                            rx_last_next = shift_reg;
                            enter_ph     = i2cms_pkg::PH_WB_SET;
                            enter_bit    = (remaining_reg > 16'd1) ? 1'b0 : 1'b1;
                        end
                    end
                    else
                    begin
                        if (active_op_reg == i2cms_pkg::OP_START_READ)
                        begin
                            remaining_next = ack_reg ? pending_reg : '0;
                        end
                        done_next = 1'b1;
                    end
                end
                i2cms_pkg::PH_SP_A:
                begin
                    enter_en = 1'b1;
                    enter_ph = i2cms_pkg::PH_SP_B;
                end
                i2cms_pkg::PH_SP_B:
                begin
                    started_next = 1'b0;
                    done_next    = 1'b1;
                end
                default:
                begin
                    done_next = 1'b1;
                end
            endcase
        end

        if (enter_en)
        begin
            phase_next       = enter_ph;
            delay_count_next = step_ticks;
            case (enter_ph)
                i2cms_pkg::PH_RESTART:
                begin
                    sda_next = 1'b1;
                    scl_next = 1'b1;
                end
                i2cms_pkg::PH_ST_SDA:  sda_next = 1'b0;
                i2cms_pkg::PH_ST_SCL:  scl_next = 1'b0;
                i2cms_pkg::PH_WB_SET:  sda_next = enter_bit;
                i2cms_pkg::PH_WB_HIGH: scl_next = 1'b1;
                i2cms_pkg::PH_WB_LOW:  scl_next = 1'b0;
                i2cms_pkg::PH_RB_HIGH:
                begin
                    sda_next = 1'b1;
                    scl_next = 1'b1;
                    // Data bits go into the shift register; otherwise this is an ACK slot.
                    if (active_op_next == i2cms_pkg::OP_READ &&
                        bit_index_next < i2cms_pkg::BITS_PER_BYTE)
                    begin
                        shift_next = {shift_next[6:0], in_sda};
                    end
                    else
                    begin
                        ack_next = !in_sda;
                    end
                end
                i2cms_pkg::PH_RB_LOW:  scl_next = 1'b0;
                i2cms_pkg::PH_SP_A:
                begin
                    sda_next = 1'b0;
                    scl_next = 1'b1;
                end
                i2cms_pkg::PH_SP_B:    sda_next = 1'b1;
                default:
                begin
                end
            endcase
        end

        if (done_next)
        begin
            phase_next       = i2cms_pkg::PH_IDLE;
            delay_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= i2cms_pkg::PH_IDLE;
            started_reg     <= 1'b0;
            remaining_reg   <= '0;
            shift_reg       <= '0;
            bit_index_reg   <= '0;
            delay_count_reg <= '0;
            active_op_reg   <= i2cms_pkg::OP_NONE;
            pending_reg     <= '0;
            ack_reg         <= 1'b0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            rx_last_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            started_reg     <= started_next;
            remaining_reg   <= remaining_next;
            shift_reg       <= shift_next;
            bit_index_reg   <= bit_index_next;
            delay_count_reg <= delay_count_next;
            active_op_reg   <= active_op_next;
            pending_reg     <= pending_next;
            ack_reg         <= ack_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
            rx_last_reg     <= rx_last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= {2'b00,
                            started_next,
                            remaining_next,
                            rx_last_next,
                            ack_next,
                            done_next,
                            (phase_next != i2cms_pkg::PH_IDLE),
                            sda_next,
                            scl_next};
        end
    end

endmodule
